// ----- hdl/usvg_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// UV sphere vertex generator: shared package
// Widths, register indexes, pipeline depths, CORDIC angle table and the
// structs that travel between the pipeline sections.
// ---------------------------------------------------------------------------
package usvg_pkg;

   localparam int IDX_W         = 11;
   localparam int RADIUS_W      = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int MAX_DIVISIONS = 1024;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS   = 2'd2;

   localparam int PHASE_W = 32;
   localparam int QUO_W   = PHASE_W + 1;
   localparam int TEX_W   = 17;
   localparam int POS_W   = 17;
   localparam int NORM_W  = 16;
   localparam int TRIG_W  = 32;

   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES    = PHASE_W / DIV_PER_STAGE;

   localparam int CORDIC_STEPS     = 24;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
   localparam int CORDIC_W         = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam int MUL_STAGES = 4;
   localparam int LATENCY    = 1 + DIV_STAGES + 1 + CORDIC_STAGES + 1 + MUL_STAGES;

   typedef struct packed {
      logic valid;
      logic err;
   } tag_type;

   typedef struct packed {
      logic             valid;
      logic             err;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } side_type;

   // atan(2^-k) in turns scaled by 2^32
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int k);
      logic signed [CORDIC_W-1:0] v;
      case (k)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/usvg_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// UV sphere vertex generator: phase and texture divider
// Pipelined restoring division of both grid indexes by their counts, two
// quotient bits per stage, then rounding into phases and texture coordinates.
// ---------------------------------------------------------------------------
module usvg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  usvg_pkg::tag_type               in_tag,
   input  logic [usvg_pkg::IDX_W-1:0]      stack_index,
   input  logic [usvg_pkg::IDX_W-1:0]      sector_index,
   input  logic [usvg_pkg::IDX_W-1:0]      row_count,
   input  logic [usvg_pkg::IDX_W-1:0]      col_count,
   output usvg_pkg::side_type              out_side,
   output logic [usvg_pkg::PHASE_W-1:0]    lat_phase,
   output logic [usvg_pkg::PHASE_W-1:0]    lon_phase
);
   import usvg_pkg::*;

   localparam int TEX_TAP = PHASE_W - (TEX_W - 1);
   localparam int LAT_TAP = PHASE_W - 1;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(64'h4000_0000);

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic [IDX_W-1:0] rem;
      logic [IDX_W-1:0] rem16;
      logic [IDX_W-1:0] rem31;
   } lane_type;

   typedef struct packed {
      tag_type  tag;
      lane_type lane_i;
      lane_type lane_j;
   } stage_type;

   function automatic lane_type lane_init(input logic [IDX_W-1:0] n,
                                          input logic [IDX_W-1:0] d);
      lane_type         l;
      logic [IDX_W:0]   dif;
      dif = {1'b0, n} - {1'b0, d};
      l = '0;
      l.quo = {{PHASE_W{1'b0}}, ~dif[IDX_W]};
      l.rem = dif[IDX_W] ? n : dif[IDX_W-1:0];
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l_in,
                                          input logic [IDX_W-1:0] d,
                                          input int n);
      lane_type       l;
      logic [IDX_W:0] dbl;
      logic [IDX_W:0] dif;
      logic           qbit;
      l    = l_in;
      dbl  = {l.rem, 1'b0};
      dif  = dbl - {1'b0, d};
      qbit = ~dif[IDX_W];
      l.rem = qbit ? dif[IDX_W-1:0] : dbl[IDX_W-1:0];
      l.quo = {l.quo[QUO_W-2:0], qbit};
      if (n == TEX_TAP) begin
         l.rem16 = l.rem;
      end
      if (n == LAT_TAP) begin
         l.rem31 = l.rem;
      end
      return l;
   endfunction

   stage_type pipe     [DIV_STAGES+1];
   stage_type stage_ff [DIV_STAGES];
   stage_type stage_in [DIV_STAGES];

   always_comb begin
      pipe[0].tag    = in_tag;
      pipe[0].lane_i = lane_init(stack_index, row_count);
      pipe[0].lane_j = lane_init(sector_index, col_count);
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         stage_type cur;
         cur = pipe[s];
         for (int k = 0; k < DIV_PER_STAGE; k++) begin
            cur.lane_i = lane_step(cur.lane_i, row_count, s * DIV_PER_STAGE + k + 1);
            cur.lane_j = lane_step(cur.lane_j, col_count, s * DIV_PER_STAGE + k + 1);
         end
         stage_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].tag.valid <= 1'b0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end

      assign pipe[s+1] = stage_ff[s];
   end

   // round half up: remainder at or above ceil(count/2) bumps the quotient
   side_type           out_side_ff, out_side_in;
   logic [PHASE_W-1:0] lat_phase_ff, lat_phase_in;
   logic [PHASE_W-1:0] lon_phase_ff, lon_phase_in;
   logic [IDX_W-1:0]   half_rows, half_cols;
   logic [QUO_W-1:0]   lon_round;
   logic [PHASE_W-1:0] lat_round;
   stage_type          last;

   always_comb begin
      last      = pipe[DIV_STAGES];
      half_rows = row_count - (row_count >> 1);
      half_cols = col_count - (col_count >> 1);
      lon_round = last.lane_j.quo + QUO_W'(last.lane_j.rem >= half_cols);
      lat_round = last.lane_i.quo[QUO_W-1:1] + PHASE_W'(last.lane_i.rem31 >= half_rows);
      lat_phase_in = QUARTER_TURN - lat_round;
      lon_phase_in = lon_round[PHASE_W-1:0];
      out_side_in.valid = last.tag.valid;
      out_side_in.err   = last.tag.err;
      out_side_in.tex_u = last.lane_j.quo[QUO_W-1:QUO_W-TEX_W]
                          + TEX_W'(last.lane_j.rem16 >= half_cols);
      out_side_in.tex_v = last.lane_i.quo[QUO_W-1:QUO_W-TEX_W]
                          + TEX_W'(last.lane_i.rem16 >= half_rows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_side_ff.valid <= 1'b0;
      end else begin
         out_side_ff  <= out_side_in;
         lat_phase_ff <= lat_phase_in;
         lon_phase_ff <= lon_phase_in;
      end
   end

   assign out_side  = out_side_ff;
   assign lat_phase = lat_phase_ff;
   assign lon_phase = lon_phase_ff;

endmodule
`default_nettype wire

// ----- hdl/usvg_cordic.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// UV sphere vertex generator: dual CORDIC
// Rotation-mode CORDIC for the latitude and longitude phases side by side,
// two micro-rotations per stage, then sign fix and clamp to +-1.0 in Q2.30.
// ---------------------------------------------------------------------------
module usvg_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  usvg_pkg::side_type                    in_side,
   input  logic [usvg_pkg::PHASE_W-1:0]          lat_phase,
   input  logic [usvg_pkg::PHASE_W-1:0]          lon_phase,
   output usvg_pkg::side_type                    out_side,
   output logic signed [usvg_pkg::TRIG_W-1:0]    cos_lat,
   output logic signed [usvg_pkg::TRIG_W-1:0]    sin_lat,
   output logic signed [usvg_pkg::TRIG_W-1:0]    cos_lon,
   output logic signed [usvg_pkg::TRIG_W-1:0]    sin_lon
);
   import usvg_pkg::*;

   localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'h8000_0000);
   localparam logic signed [CORDIC_W-1:0] ONE       = CORDIC_W'(64'h4000_0000);

   typedef struct packed {
      logic signed [CORDIC_W-1:0] ang;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic                       neg;
   } lane_type;

   typedef struct packed {
      side_type side;
      lane_type lat;
      lane_type lon;
   } stage_type;

   // fold into [-1/4, 1/4) turn; the far half is rotated by half a turn
   function automatic lane_type lane_init(input logic [PHASE_W-1:0] phase);
      lane_type                   l;
      logic signed [CORDIC_W-1:0] a;
      a = {{(CORDIC_W-PHASE_W){phase[PHASE_W-1]}}, phase};
      l.neg = 1'b0;
      if (phase[PHASE_W-1:PHASE_W-2] == 2'b01) begin
         a     = a - HALF_TURN;
         l.neg = 1'b1;
      end else if (phase[PHASE_W-1:PHASE_W-2] == 2'b10) begin
         a     = a + HALF_TURN;
         l.neg = 1'b1;
      end
      l.ang = a;
      l.x   = CORDIC_GAIN;
      l.y   = '0;
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l_in, input int k);
      lane_type                   l;
      logic signed [CORDIC_W-1:0] x, y, a, dx, dy, t;
      l  = l_in;
      x  = l.x;
      y  = l.y;
      a  = l.ang;
      dx = y >>> k;
      dy = x >>> k;
      t  = atan_turn(k);
      if (!a[CORDIC_W-1]) begin
         x = x - dx;
         y = y + dy;
         a = a - t;
      end else begin
         x = x + dx;
         y = y - dy;
         a = a + t;
      end
      l.x   = x;
      l.y   = y;
      l.ang = a;
      return l;
   endfunction

   function automatic logic signed [TRIG_W-1:0] finish(input logic signed [CORDIC_W-1:0] v,
                                                       input logic neg);
      logic signed [CORDIC_W-1:0] r;
      r = neg ? -v : v;
      if (r > ONE) begin
         r = ONE;
      end else if (r < -ONE) begin
         r = -ONE;
      end
      return $signed(r[TRIG_W-1:0]);
   endfunction

   stage_type pipe     [CORDIC_STAGES+1];
   stage_type stage_ff [CORDIC_STAGES];
   stage_type stage_in [CORDIC_STAGES];

   always_comb begin
      pipe[0].side = in_side;
      pipe[0].lat  = lane_init(lat_phase);
      pipe[0].lon  = lane_init(lon_phase);
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      always_comb begin
         stage_type cur;
         cur = pipe[s];
         for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
            cur.lat = lane_step(cur.lat, s * CORDIC_PER_STAGE + k);
            cur.lon = lane_step(cur.lon, s * CORDIC_PER_STAGE + k);
         end
         stage_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].side.valid <= 1'b0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end

      assign pipe[s+1] = stage_ff[s];
   end

   side_type                 out_side_ff;
   logic signed [TRIG_W-1:0] cos_lat_ff, sin_lat_ff, cos_lon_ff, sin_lon_ff;
   logic signed [TRIG_W-1:0] cos_lat_in, sin_lat_in, cos_lon_in, sin_lon_in;
   stage_type                last;

   always_comb begin
      last       = pipe[CORDIC_STAGES];
      cos_lat_in = finish(last.lat.x, last.lat.neg);
      sin_lat_in = finish(last.lat.y, last.lat.neg);
      cos_lon_in = finish(last.lon.x, last.lon.neg);
      sin_lon_in = finish(last.lon.y, last.lon.neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_side_ff.valid <= 1'b0;
      end else begin
         out_side_ff <= last.side;
         cos_lat_ff  <= cos_lat_in;
         sin_lat_ff  <= sin_lat_in;
         cos_lon_ff  <= cos_lon_in;
         sin_lon_ff  <= sin_lon_in;
      end
   end

   assign out_side = out_side_ff;
   assign cos_lat  = cos_lat_ff;
   assign sin_lat  = sin_lat_ff;
   assign cos_lon  = cos_lon_ff;
   assign sin_lon  = sin_lon_ff;

endmodule
`default_nettype wire

// ----- hdl/usvg_mul.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// UV sphere vertex generator: position and normal products
// Four stages: products, rounding of the first products, radius products on
// longitude, final rounding with error masking into the result registers.
// ---------------------------------------------------------------------------
module usvg_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  usvg_pkg::side_type                  in_side,
   input  logic [usvg_pkg::RADIUS_W-1:0]       radius,
   input  logic signed [usvg_pkg::TRIG_W-1:0]  cos_lat,
   input  logic signed [usvg_pkg::TRIG_W-1:0]  sin_lat,
   input  logic signed [usvg_pkg::TRIG_W-1:0]  cos_lon,
   input  logic signed [usvg_pkg::TRIG_W-1:0]  sin_lon,
   output logic                                out_valid,
   output logic signed [usvg_pkg::POS_W-1:0]   pos_x,
   output logic signed [usvg_pkg::POS_W-1:0]   pos_y,
   output logic signed [usvg_pkg::POS_W-1:0]   pos_z,
   output logic signed [usvg_pkg::NORM_W-1:0]  normal_x,
   output logic signed [usvg_pkg::NORM_W-1:0]  normal_y,
   output logic signed [usvg_pkg::NORM_W-1:0]  normal_z,
   output logic [usvg_pkg::TEX_W-1:0]          tex_u,
   output logic [usvg_pkg::TEX_W-1:0]          tex_v,
   output logic                                index_error
);
   import usvg_pkg::*;

   localparam int RP_W  = RADIUS_W + 1 + TRIG_W;
   localparam int TP_W  = 2 * TRIG_W;
   localparam int SAT_W = 34;

   localparam logic signed [RP_W-1:0] RND15 = RP_W'(64'sd1 <<< 14);
   localparam logic signed [RP_W-1:0] RND30 = RP_W'(64'sd1 <<< 29);
   localparam logic signed [TP_W-1:0] RND45 = TP_W'(64'sd1 <<< 44);
   localparam logic signed [TRIG_W:0] RND15_T = (TRIG_W+1)'(64'sd1 <<< 14);
   localparam logic signed [SAT_W-1:0] NORM_MAX = SAT_W'((64'sd1 <<< (NORM_W-1)) - 1);
   localparam logic signed [SAT_W-1:0] NORM_MIN = -SAT_W'(64'sd1 <<< (NORM_W-1));

   function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      r = v;
      if (r > NORM_MAX) begin
         r = NORM_MAX;
      end else if (r < NORM_MIN) begin
         r = NORM_MIN;
      end
      return $signed(r[NORM_W-1:0]);
   endfunction

   // stage 1
   side_type                 s1_side_ff;
   logic signed [RP_W-1:0]   s1_prc_ff, s1_prs_ff;
   logic signed [TP_W-1:0]   s1_pnx_ff, s1_pny_ff;
   logic signed [NORM_W-1:0] s1_nz_ff, s1_nz_in;
   logic signed [TRIG_W-1:0] s1_cn_ff, s1_sn_ff;
   logic signed [RP_W-1:0]   s1_prc_in, s1_prs_in;
   logic signed [TP_W-1:0]   s1_pnx_in, s1_pny_in;
   logic signed [TRIG_W:0]   nz_sum;
   logic signed [TRIG_W:0]   nz_shift;

   always_comb begin
      s1_prc_in = $signed({1'b0, radius}) * cos_lat;
      s1_prs_in = $signed({1'b0, radius}) * sin_lat;
      s1_pnx_in = cos_lat * cos_lon;
      s1_pny_in = cos_lat * sin_lon;
      nz_sum    = {sin_lat[TRIG_W-1], sin_lat} + RND15_T;
      nz_shift  = nz_sum >>> 15;
      s1_nz_in  = sat_norm(SAT_W'(nz_shift));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
      end else begin
         s1_side_ff <= in_side;
         s1_prc_ff  <= s1_prc_in;
         s1_prs_ff  <= s1_prs_in;
         s1_pnx_ff  <= s1_pnx_in;
         s1_pny_ff  <= s1_pny_in;
         s1_nz_ff   <= s1_nz_in;
         s1_cn_ff   <= cos_lon;
         s1_sn_ff   <= sin_lon;
      end
   end

   // stage 2: round the first products
   side_type                 s2_side_ff;
   logic signed [TRIG_W-1:0] s2_t_ff, s2_t_in;
   logic signed [POS_W-1:0]  s2_pz_ff, s2_pz_in;
   logic signed [NORM_W-1:0] s2_nx_ff, s2_ny_ff, s2_nz_ff, s2_nx_in, s2_ny_in;
   logic signed [TRIG_W-1:0] s2_cn_ff, s2_sn_ff;
   logic signed [RP_W-1:0]   t_full, pz_full;
   logic signed [TP_W-1:0]   nx_full, ny_full;

   always_comb begin
      t_full   = (s1_prc_ff + RND15) >>> 15;
      pz_full  = (s1_prs_ff + RND30) >>> 30;
      nx_full  = (s1_pnx_ff + RND45) >>> 45;
      ny_full  = (s1_pny_ff + RND45) >>> 45;
      s2_t_in  = $signed(t_full[TRIG_W-1:0]);
      s2_pz_in = $signed(pz_full[POS_W-1:0]);
      s2_nx_in = sat_norm($signed(nx_full[SAT_W-1:0]));
      s2_ny_in = sat_norm($signed(ny_full[SAT_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else begin
         s2_side_ff <= s1_side_ff;
         s2_t_ff    <= s2_t_in;
         s2_pz_ff   <= s2_pz_in;
         s2_nx_ff   <= s2_nx_in;
         s2_ny_ff   <= s2_ny_in;
         s2_nz_ff   <= s1_nz_ff;
         s2_cn_ff   <= s1_cn_ff;
         s2_sn_ff   <= s1_sn_ff;
      end
   end

   // stage 3: scaled ring radius times longitude
   side_type                 s3_side_ff;
   logic signed [TP_W-1:0]   s3_px_ff, s3_py_ff, s3_px_in, s3_py_in;
   logic signed [POS_W-1:0]  s3_pz_ff;
   logic signed [NORM_W-1:0] s3_nx_ff, s3_ny_ff, s3_nz_ff;

   always_comb begin
      s3_px_in = s2_t_ff * s2_cn_ff;
      s3_py_in = s2_t_ff * s2_sn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else begin
         s3_side_ff <= s2_side_ff;
         s3_px_ff   <= s3_px_in;
         s3_py_ff   <= s3_py_in;
         s3_pz_ff   <= s2_pz_ff;
         s3_nx_ff   <= s2_nx_ff;
         s3_ny_ff   <= s2_ny_ff;
         s3_nz_ff   <= s2_nz_ff;
      end
   end

   // stage 4: final rounding, zero positions, normals and texture coordinates on an index error
   logic                     valid_ff;
   logic signed [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [POS_W-1:0]  pos_x_in, pos_y_in, pos_z_in;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [TEX_W-1:0]         tex_u_ff, tex_v_ff, tex_u_in, tex_v_in;
   logic                     err_ff;
   logic signed [TP_W-1:0]   px_full, py_full;
   logic                     kill;

   always_comb begin
      kill     = s3_side_ff.err;
      px_full  = (s3_px_ff + RND45) >>> 45;
      py_full  = (s3_py_ff + RND45) >>> 45;
      pos_x_in = kill ? '0 : $signed(px_full[POS_W-1:0]);
      pos_y_in = kill ? '0 : $signed(py_full[POS_W-1:0]);
      pos_z_in = kill ? '0 : s3_pz_ff;
      nx_in    = kill ? '0 : s3_nx_ff;
      ny_in    = kill ? '0 : s3_ny_ff;
      nz_in    = kill ? '0 : s3_nz_ff;
      tex_u_in = kill ? '0 : s3_side_ff.tex_u;
      tex_v_in = kill ? '0 : s3_side_ff.tex_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s3_side_ff.valid;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         nz_ff    <= nz_in;
         tex_u_ff <= tex_u_in;
         tex_v_ff <= tex_v_in;
         err_ff   <= kill;
      end
   end

   assign out_valid   = valid_ff;
   assign pos_x       = pos_x_ff;
   assign pos_y       = pos_y_ff;
   assign pos_z       = pos_z_ff;
   assign normal_x    = nx_ff;
   assign normal_y    = ny_ff;
   assign normal_z    = nz_ff;
   assign tex_u       = tex_u_ff;
   assign tex_v       = tex_v_ff;
   assign index_error = err_ff;

endmodule
`default_nettype wire

// ----- hdl/uv_sphere_vertex_generator_top.sv -----
`default_nettype none
// Pipeline: 35 register stages.
// Throughput: one request per cycle; busy never rises and the result is
//   shown for one cycle only, as the receiver cannot stall.
// Depth is set by the divider (two quotient bits per stage, 16 stages) and
//   the CORDIC (two rotations per stage, 12 stages), plus four product stages.
// Reset clears every valid bit and loads radius 1.0, 16 stacks, 32 sectors.
// ---------------------------------------------------------------------------
// UV sphere vertex generator
// Turns one grid point (stack, sector) into vertex position, unit normal and
// texture coordinates of a UV sphere, fully pipelined.
// ---------------------------------------------------------------------------
module uv_sphere_vertex_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [usvg_pkg::IDX_W-1:0]          req_stack_index,
   input  logic [usvg_pkg::IDX_W-1:0]          req_sector_index,
   input  logic                                csr_write_enable,
   input  logic [usvg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [usvg_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   output logic signed [usvg_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [usvg_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [usvg_pkg::POS_W-1:0]   rsp_pos_z,
   output logic signed [usvg_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [usvg_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [usvg_pkg::NORM_W-1:0]  rsp_normal_z,
   output logic [usvg_pkg::TEX_W-1:0]          rsp_tex_u,
   output logic [usvg_pkg::TEX_W-1:0]          rsp_tex_v,
   output logic                                rsp_index_error
);
   import usvg_pkg::*;

   localparam logic [IDX_W-1:0] MAX_COUNT = IDX_W'(MAX_DIVISIONS);

   // configuration registers; the user must write them only while the pipeline is empty
   // (the block itself does not enforce this), so every stage may read them directly
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [IDX_W-1:0]    row_count_ff, row_count_in;
   logic [IDX_W-1:0]    col_count_ff, col_count_in;

   always_comb begin
      radius_in    = radius_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_RADIUS: radius_in    = csr_data[RADIUS_W-1:0];
            REG_ROWS:   row_count_in = csr_data[IDX_W-1:0];
            REG_COLS:   col_count_in = csr_data[IDX_W-1:0];
            default:    ; // unknown register: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_W'(256);
         row_count_ff <= IDX_W'(16);
         col_count_ff <= IDX_W'(32);
      end else begin
         radius_ff    <= radius_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // request capture; a bad count or an index past its count marks the
   // request as an index error, which blanks the result at the far end
   logic             accept;
   logic             bad_request;
   tag_type          in_tag_ff, in_tag_in;
   logic [IDX_W-1:0] stack_ff, sector_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      bad_request = (row_count_ff == '0) || (col_count_ff == '0)
                 || (row_count_ff > MAX_COUNT) || (col_count_ff > MAX_COUNT)
                 || (req_stack_index > row_count_ff)
                 || (req_sector_index > col_count_ff);
      in_tag_in.valid = accept;
      in_tag_in.err   = bad_request;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff.valid <= 1'b0;
      end else begin
         in_tag_ff <= in_tag_in;
         stack_ff  <= req_stack_index;
         sector_ff <= req_sector_index;
      end
   end

   // divider: phases and texture coordinates
   side_type           div_side;
   logic [PHASE_W-1:0] lat_phase, lon_phase;

   usvg_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (in_tag_ff),
      .stack_index  (stack_ff),
      .sector_index (sector_ff),
      .row_count    (row_count_ff),
      .col_count    (col_count_ff),
      .out_side     (div_side),
      .lat_phase    (lat_phase),
      .lon_phase    (lon_phase)
   );

   // CORDIC: sine and cosine of both angles
   side_type                 cordic_side;
   logic signed [TRIG_W-1:0] cos_lat, sin_lat, cos_lon, sin_lon;

   usvg_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_side   (div_side),
      .lat_phase (lat_phase),
      .lon_phase (lon_phase),
      .out_side  (cordic_side),
      .cos_lat   (cos_lat),
      .sin_lat   (sin_lat),
      .cos_lon   (cos_lon),
      .sin_lon   (sin_lon)
   );

   // products, rounding and the result registers
   usvg_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_side     (cordic_side),
      .radius      (radius_ff),
      .cos_lat     (cos_lat),
      .sin_lat     (sin_lat),
      .cos_lon     (cos_lon),
      .sin_lon     (sin_lon),
      .out_valid   (rsp_valid),
      .pos_x       (rsp_pos_x),
      .pos_y       (rsp_pos_y),
      .pos_z       (rsp_pos_z),
      .normal_x    (rsp_normal_x),
      .normal_y    (rsp_normal_y),
      .normal_z    (rsp_normal_z),
      .tex_u       (rsp_tex_u),
      .tex_v       (rsp_tex_v),
      .index_error (rsp_index_error)
   );

   // every accepted request comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request lost in pipeline");

   // no result without a request the fixed latency before
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without request");

   // an index error blanks every other field
   a_error_blank : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |->
         (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0 &&
          rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 &&
          rsp_tex_u == '0 && rsp_tex_v == '0))
      else $error("index error result not blanked");

   // texture coordinates never pass 1.0
   a_tex_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_error) |->
         (rsp_tex_u <= TEX_W'(65536) && rsp_tex_v <= TEX_W'(65536)))
      else $error("texture coordinate out of range");

endmodule
`default_nettype wire
